// ----- design/cprg_pkg.sv -----
`default_nettype none
package cprg_pkg;

    localparam int DIR_W_DEF = 16;

    // configuration register indexes
    localparam logic [2:0] REG_RIGHT_AXIS    = 3'd0;
    localparam logic [2:0] REG_UP_AXIS       = 3'd1;
    localparam logic [2:0] REG_VIEW_AXIS     = 3'd2;
    localparam logic [2:0] REG_FRUSTUM_RIGHT = 3'd3;
    localparam logic [2:0] REG_FRUSTUM_UP    = 3'd4;
    localparam logic [2:0] REG_NEAR_DISTANCE = 3'd5;
    localparam logic [2:0] REG_VIEWPORT      = 3'd6;
    localparam logic [2:0] REG_SCREEN_SIZE   = 3'd7;

    localparam logic [47:0] RST_RIGHT_AXIS    = 48'h0000_0000_4000;
    localparam logic [47:0] RST_UP_AXIS       = 48'h0000_4000_0000;
    localparam logic [47:0] RST_VIEW_AXIS     = 48'h4000_0000_0000;
    localparam logic [47:0] RST_FRUSTUM_RIGHT = 48'h0008_00FF_F800;
    localparam logic [47:0] RST_FRUSTUM_UP    = 48'h0008_00FF_F800;
    localparam logic [23:0] RST_NEAR_DISTANCE = 24'h00_1000;
    localparam logic [47:0] RST_VIEWPORT      = 48'h8000_0080_0000;
    localparam logic [31:0] RST_SCREEN_SIZE   = 32'h01E0_0500;

    // normalised magnitudes have their top bit here
    localparam int NORM_MSB = 29;

endpackage
`default_nettype wire

// ----- design/cprg_div.sv -----
`default_nettype none
module cprg_div #(
    parameter int LANES = 2,
    parameter int N_W = 54,
    parameter int D_W = 29,
    parameter int Q_W = 24,
    parameter int S_W = 1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       vld_in,
    input  wire logic [LANES-1:0][N_W-1:0]  num,
    input  wire logic [LANES-1:0][D_W-1:0]  den,
    input  wire logic [S_W-1:0]             side_in,
    output logic                            vld_out,
    output logic [LANES-1:0][Q_W-1:0]       quo,
    output logic [S_W-1:0]                  side_out
);

    localparam int CW = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

    logic [CW-1:0]  rem_reg  [Q_W][LANES];
    logic [CW-1:0]  rem_next [Q_W][LANES];
    logic [Q_W-1:0] quo_reg  [Q_W][LANES];
    logic [Q_W-1:0] quo_next [Q_W][LANES];
    logic [D_W-1:0] den_reg  [Q_W][LANES];
    logic [D_W-1:0] den_next [Q_W][LANES];
    logic [S_W-1:0] side_reg [Q_W];
    logic [S_W-1:0] side_next [Q_W];
    logic [Q_W-1:0] vld_reg;

    // one quotient bit per stage, most significant first
    always_comb
    begin
        logic [CW-1:0]  rem_in;
        logic [CW-1:0]  dsh;
        logic [Q_W-1:0] quo_in;
        logic [D_W-1:0] den_in;
        for (int k = 0; k < Q_W; k++)
        begin
            side_next[k] = (k == 0) ? side_in : side_reg[(k == 0) ? 0 : k - 1];
            for (int l = 0; l < LANES; l++)
            begin
                if (k == 0)
                begin
                    rem_in = CW'(num[l]);
                    quo_in = '0;
                    den_in = den[l];
                end
                else
                begin
                    rem_in = rem_reg[k-1][l];
                    quo_in = quo_reg[k-1][l];
                    den_in = den_reg[k-1][l];
                end
                dsh = CW'(den_in) << (Q_W - 1 - k);
                den_next[k][l] = den_in;
                quo_next[k][l] = quo_in;
                rem_next[k][l] = rem_in;
                if (rem_in >= dsh)
                begin
                    rem_next[k][l] = rem_in - dsh;
                    quo_next[k][l][Q_W-1-k] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[Q_W-2:0], vld_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < Q_W; k++)
            begin
                side_reg[k] <= side_next[k];
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[k][l] <= rem_next[k][l];
                    quo_reg[k][l] <= quo_next[k][l];
                    den_reg[k][l] <= den_next[k][l];
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            quo[l] = quo_reg[Q_W-1][l];
        end
    end

    assign vld_out  = vld_reg[Q_W-1];
    assign side_out = side_reg[Q_W-1];

endmodule
`default_nettype wire

// ----- design/cprg_sqrt.sv -----
`default_nettype none
module cprg_sqrt #(
    parameter int RT_W = 31,
    parameter int S_W = 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                vld_in,
    input  wire logic [2*RT_W-1:0]   rad,
    input  wire logic [S_W-1:0]      side_in,
    output logic                     vld_out,
    output logic [RT_W-1:0]          root,
    output logic [S_W-1:0]           side_out
);

    localparam int SQ_W = 2 * RT_W;

    logic [SQ_W-1:0] s_reg  [RT_W];
    logic [SQ_W-1:0] s_next [RT_W];
    logic [SQ_W-1:0] r_reg  [RT_W];
    logic [SQ_W-1:0] r_next [RT_W];
    logic [S_W-1:0]  side_reg  [RT_W];
    logic [S_W-1:0]  side_next [RT_W];
    logic [RT_W-1:0] vld_reg;

    // digit-by-digit root, one result bit per stage
    always_comb
    begin
        logic [SQ_W-1:0] s_in;
        logic [SQ_W-1:0] r_in;
        logic [SQ_W:0]   one_v;
        logic [SQ_W:0]   trial;
        for (int k = 0; k < RT_W; k++)
        begin
            if (k == 0)
            begin
                s_in = rad;
                r_in = '0;
                side_next[k] = side_in;
            end
            else
            begin
                s_in = s_reg[k-1];
                r_in = r_reg[k-1];
                side_next[k] = side_reg[k-1];
            end
            one_v = '0;
            one_v[2*(RT_W-1-k)] = 1'b1;
            trial = {1'b0, r_in} + one_v;
            if ({1'b0, s_in} >= trial)
            begin
                s_next[k] = s_in - trial[SQ_W-1:0];
                r_next[k] = (r_in >> 1) + one_v[SQ_W-1:0];
            end
            else
            begin
                s_next[k] = s_in;
                r_next[k] = r_in >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[RT_W-2:0], vld_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < RT_W; k++)
            begin
                s_reg[k]    <= s_next[k];
                r_reg[k]    <= r_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    assign vld_out  = vld_reg[RT_W-1];
    assign root     = r_reg[RT_W-1][RT_W-1:0];
    assign side_out = side_reg[RT_W-1];

endmodule
`default_nettype wire

// ----- design/camera_pick_ray_generator_unit.sv -----
// throughput: one pixel per cycle; a stalled output holds the whole pipeline
// the pipe is set by the 24-stage extent divider, the 31-stage square root and
// the (DIRECTION_WIDTH - 1)-stage normalising divider
// reset: asynchronous, active low; clears all valid bits and loads the default camera
`default_nettype none
module camera_pick_ray_generator_unit #(
    parameter int DIRECTION_WIDTH = cprg_pkg::DIR_W_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [15:0]                       pixel_x,
    input  wire logic [15:0]                       pixel_y,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   hit,
    output logic signed [DIRECTION_WIDTH-1:0]      dir_x,
    output logic signed [DIRECTION_WIDTH-1:0]      dir_y,
    output logic signed [DIRECTION_WIDTH-1:0]      dir_z,
    input  wire logic                              cfg_we,
    input  wire logic [2:0]                        cfg_index,
    input  wire logic [47:0]                       cfg_data
);

    localparam int DW     = DIRECTION_WIDTH;
    localparam int LN_W   = 54;
    localparam int LD_W   = 29;
    localparam int LQ_W   = 24;
    localparam int LS_W   = 51;
    localparam int VX_W   = 26;
    localparam int P_W    = 42;
    localparam int V_W    = 44;
    localparam int MAG_W  = 43;
    localparam int NORM_W = cprg_pkg::NORM_MSB + 1;
    localparam int SQ_W   = 2 * NORM_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int RT_W   = SUM_W / 2;
    localparam int RS_W   = 5 + 3 * NORM_W;
    localparam int NN_W   = DW + 30;
    localparam int ND_W   = RT_W + 1;
    localparam int NQ_W   = DW - 1;

    // configuration
    logic [47:0] right_axis_reg, up_axis_reg, view_axis_reg;
    logic [47:0] frustum_right_reg, frustum_up_reg, viewport_reg;
    logic [23:0] near_distance_reg;
    logic [31:0] screen_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_axis_reg    <= cprg_pkg::RST_RIGHT_AXIS;
            up_axis_reg       <= cprg_pkg::RST_UP_AXIS;
            view_axis_reg     <= cprg_pkg::RST_VIEW_AXIS;
            frustum_right_reg <= cprg_pkg::RST_FRUSTUM_RIGHT;
            frustum_up_reg    <= cprg_pkg::RST_FRUSTUM_UP;
            near_distance_reg <= cprg_pkg::RST_NEAR_DISTANCE;
            viewport_reg      <= cprg_pkg::RST_VIEWPORT;
            screen_size_reg   <= cprg_pkg::RST_SCREEN_SIZE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cprg_pkg::REG_RIGHT_AXIS:    right_axis_reg    <= cfg_data;
                cprg_pkg::REG_UP_AXIS:       up_axis_reg       <= cfg_data;
                cprg_pkg::REG_VIEW_AXIS:     view_axis_reg     <= cfg_data;
                cprg_pkg::REG_FRUSTUM_RIGHT: frustum_right_reg <= cfg_data;
                cprg_pkg::REG_FRUSTUM_UP:    frustum_up_reg    <= cfg_data;
                cprg_pkg::REG_NEAR_DISTANCE: near_distance_reg <= cfg_data[23:0];
                cprg_pkg::REG_VIEWPORT:      viewport_reg      <= cfg_data;
                cprg_pkg::REG_SCREEN_SIZE:   screen_size_reg   <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    logic [15:0] scr_w, scr_h, wm, hm;
    logic [11:0] vp_l, vp_r, vp_b, vp_t;

    assign scr_w = screen_size_reg[15:0];
    assign scr_h = screen_size_reg[31:16];
    assign wm    = scr_w - 16'd1;
    assign hm    = scr_h - 16'd1;
    assign vp_l  = viewport_reg[11:0];
    assign vp_r  = viewport_reg[23:12];
    assign vp_b  = viewport_reg[35:24];
    assign vp_t  = viewport_reg[47:36];

    // whole pipe moves unless a finished result is held
    logic out_valid_reg;
    logic adv;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // stage 1: viewport edges in pixel units
    logic        s1_vld_reg;
    logic [15:0] s1_x_reg, s1_ny_reg;
    logic        s1_ybad_reg, s1_cbad_reg;
    logic [27:0] s1_plw_reg, s1_prw_reg, s1_pbh_reg, s1_pth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x_reg    <= pixel_x;
            s1_ny_reg   <= hm - pixel_y;
            s1_ybad_reg <= pixel_y > hm;
            s1_cbad_reg <= (scr_w < 16'd2) || (scr_h < 16'd2) || (vp_r <= vp_l)
                           || (vp_t <= vp_b);
            s1_plw_reg  <= 28'(vp_l) * 28'(wm);
            s1_prw_reg  <= 28'(vp_r) * 28'(wm);
            s1_pbh_reg  <= 28'(vp_b) * 28'(hm);
            s1_pth_reg  <= 28'(vp_t) * 28'(hm);
        end
    end

    // stage 2: viewport test, interpolation numerators and extent spans
    logic [27:0] s2_xs_next, s2_ys_next;
    logic signed [24:0] s2_dx_next, s2_dy_next, s2_ndx_next, s2_ndy_next;
    logic        s2_vld_reg, s2_hit_reg, s2_negx_reg, s2_negy_reg;
    logic [27:0] s2_numx_reg, s2_denx_reg, s2_numy_reg, s2_deny_reg;
    logic [23:0] s2_absx_reg, s2_absy_reg, s2_lox_reg, s2_loy_reg;

    always_comb
    begin
        s2_xs_next  = {1'b0, s1_x_reg, 11'b0};
        s2_ys_next  = {1'b0, s1_ny_reg, 11'b0};
        s2_dx_next  = $signed({frustum_right_reg[47], frustum_right_reg[47:24]})
                      - $signed({frustum_right_reg[23], frustum_right_reg[23:0]});
        s2_dy_next  = $signed({frustum_up_reg[47], frustum_up_reg[47:24]})
                      - $signed({frustum_up_reg[23], frustum_up_reg[23:0]});
        s2_ndx_next = -s2_dx_next;
        s2_ndy_next = -s2_dy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_hit_reg  <= !(s1_cbad_reg || s1_ybad_reg
                             || (s2_xs_next < s1_plw_reg) || (s2_xs_next > s1_prw_reg)
                             || (s2_ys_next < s1_pbh_reg) || (s2_ys_next > s1_pth_reg));
            s2_numx_reg <= s2_xs_next - s1_plw_reg;
            s2_denx_reg <= s1_prw_reg - s1_plw_reg;
            s2_numy_reg <= s2_ys_next - s1_pbh_reg;
            s2_deny_reg <= s1_pth_reg - s1_pbh_reg;
            s2_negx_reg <= s2_dx_next[24];
            s2_negy_reg <= s2_dy_next[24];
            s2_absx_reg <= s2_dx_next[24] ? s2_ndx_next[23:0] : s2_dx_next[23:0];
            s2_absy_reg <= s2_dy_next[24] ? s2_ndy_next[23:0] : s2_dy_next[23:0];
            s2_lox_reg  <= frustum_right_reg[23:0];
            s2_loy_reg  <= frustum_up_reg[23:0];
        end
    end

    // stage 3: numerator times span
    logic        s3_vld_reg;
    logic [51:0] s3_prodx_reg, s3_prody_reg;
    logic [27:0] s3_denx_reg, s3_deny_reg;
    logic [LS_W-1:0] s3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_prodx_reg <= 52'(s2_numx_reg) * 52'(s2_absx_reg);
            s3_prody_reg <= 52'(s2_numy_reg) * 52'(s2_absy_reg);
            s3_denx_reg  <= s2_denx_reg;
            s3_deny_reg  <= s2_deny_reg;
            s3_side_reg  <= {s2_hit_reg, s2_negy_reg, s2_negx_reg, s2_loy_reg, s2_lox_reg};
        end
    end

    // rounded quotient: (2n + d) / 2d
    logic [1:0][LN_W-1:0] ld_num;
    logic [1:0][LD_W-1:0] ld_den;
    logic [1:0][LQ_W-1:0] ld_quo;
    logic [LS_W-1:0]      ld_side;
    logic                 ld_vld;

    assign ld_num[0] = {s3_prodx_reg, 1'b0} + LN_W'(s3_denx_reg);
    assign ld_num[1] = {s3_prody_reg, 1'b0} + LN_W'(s3_deny_reg);
    assign ld_den[0] = {s3_denx_reg, 1'b0};
    assign ld_den[1] = {s3_deny_reg, 1'b0};

    cprg_div #(
        .LANES (2),
        .N_W   (LN_W),
        .D_W   (LD_W),
        .Q_W   (LQ_W),
        .S_W   (LS_W)
    ) u_lerp_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .vld_in   (s3_vld_reg),
        .num      (ld_num),
        .den      (ld_den),
        .side_in  (s3_side_reg),
        .vld_out  (ld_vld),
        .quo      (ld_quo),
        .side_out (ld_side)
    );

    // interpolated extents
    logic                   vx_vld_reg, vx_hit_reg;
    logic signed [VX_W-1:0] vx_reg, vy_reg;
    logic signed [VX_W-1:0] lox_ext, loy_ext;

    assign lox_ext = $signed({{2{ld_side[23]}}, ld_side[23:0]});
    assign loy_ext = $signed({{2{ld_side[47]}}, ld_side[47:24]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vx_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vx_vld_reg <= ld_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vx_hit_reg <= ld_side[50];
            vx_reg <= ld_side[48] ? lox_ext - $signed({2'b0, ld_quo[0]})
                                  : lox_ext + $signed({2'b0, ld_quo[0]});
            vy_reg <= ld_side[49] ? loy_ext - $signed({2'b0, ld_quo[1]})
                                  : loy_ext + $signed({2'b0, ld_quo[1]});
        end
    end

    // axis products
    logic                  pr_vld_reg, pr_hit_reg;
    logic signed [P_W-1:0] pn_reg [3];
    logic signed [P_W-1:0] prt_reg [3];
    logic signed [P_W-1:0] pup_reg [3];
    logic signed [P_W-1:0] pn_next [3];
    logic signed [P_W-1:0] prt_next [3];
    logic signed [P_W-1:0] pup_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pn_next[i]  = P_W'($signed({1'b0, near_distance_reg}))
                          * P_W'($signed(view_axis_reg[16*i +: 16]));
            prt_next[i] = P_W'(vx_reg) * P_W'($signed(right_axis_reg[16*i +: 16]));
            pup_next[i] = P_W'(vy_reg) * P_W'($signed(up_axis_reg[16*i +: 16]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            pr_vld_reg <= vx_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr_hit_reg <= vx_hit_reg;
            for (int i = 0; i < 3; i++)
            begin
                pn_reg[i]  <= pn_next[i];
                prt_reg[i] <= prt_next[i];
                pup_reg[i] <= pup_next[i];
            end
        end
    end

    // direction sum
    logic                  sm_vld_reg, sm_hit_reg;
    logic signed [V_W-1:0] v_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sm_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            sm_vld_reg <= pr_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sm_hit_reg <= pr_hit_reg;
            for (int i = 0; i < 3; i++)
            begin
                v_reg[i] <= V_W'(pn_reg[i]) + V_W'(prt_reg[i]) + V_W'(pup_reg[i]);
            end
        end
    end

    // magnitudes and signs
    logic             mg_vld_reg, mg_hit_reg;
    logic [2:0]       mg_neg_reg;
    logic [MAG_W-1:0] mg_reg [3];
    logic [V_W-1:0]   mg_abs [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mg_abs[i] = v_reg[i][V_W-1] ? V_W'(-v_reg[i]) : V_W'(v_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mg_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            mg_vld_reg <= sm_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mg_hit_reg <= sm_hit_reg;
            for (int i = 0; i < 3; i++)
            begin
                mg_reg[i]     <= mg_abs[i][MAG_W-1:0];
                mg_neg_reg[i] <= v_reg[i][V_W-1];
            end
        end
    end

    // leading one of the largest magnitude (msb of the or of all three)
    logic             pe_vld_reg, pe_hit_reg, pe_zero_reg;
    logic [2:0]       pe_neg_reg;
    logic [5:0]       pe_pos_reg;
    logic [MAG_W-1:0] pe_mag_reg [3];
    logic [MAG_W-1:0] pe_or;
    logic [5:0]       pe_pos_next;

    always_comb
    begin
        pe_or = mg_reg[0] | mg_reg[1] | mg_reg[2];
        pe_pos_next = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (pe_or[i])
            begin
                pe_pos_next = 6'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pe_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            pe_vld_reg <= mg_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pe_hit_reg  <= mg_hit_reg;
            pe_zero_reg <= pe_or == '0;
            pe_neg_reg  <= mg_neg_reg;
            pe_pos_reg  <= pe_pos_next;
            for (int i = 0; i < 3; i++)
            begin
                pe_mag_reg[i] <= mg_reg[i];
            end
        end
    end

    // common shift so the largest lands in [2^29, 2^30)
    logic              ns_vld_reg, ns_hit_reg, ns_zero_reg;
    logic [2:0]        ns_neg_reg;
    logic [NORM_W-1:0] ns_mag_reg [3];
    logic [NORM_W-1:0] ns_mag_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (pe_pos_reg >= 6'(cprg_pkg::NORM_MSB))
            begin
                ns_mag_next[i] = NORM_W'(pe_mag_reg[i]
                                         >> (pe_pos_reg - 6'(cprg_pkg::NORM_MSB)));
            end
            else
            begin
                ns_mag_next[i] = NORM_W'(pe_mag_reg[i]
                                         << (6'(cprg_pkg::NORM_MSB) - pe_pos_reg));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ns_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            ns_vld_reg <= pe_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ns_hit_reg  <= pe_hit_reg;
            ns_zero_reg <= pe_zero_reg;
            ns_neg_reg  <= pe_neg_reg;
            for (int i = 0; i < 3; i++)
            begin
                ns_mag_reg[i] <= ns_mag_next[i];
            end
        end
    end

    // squares
    logic              sq_vld_reg, sq_hit_reg, sq_zero_reg;
    logic [2:0]        sq_neg_reg;
    logic [NORM_W-1:0] sq_mag_reg [3];
    logic [SQ_W-1:0]   sq_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            sq_vld_reg <= ns_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_hit_reg  <= ns_hit_reg;
            sq_zero_reg <= ns_zero_reg;
            sq_neg_reg  <= ns_neg_reg;
            for (int i = 0; i < 3; i++)
            begin
                sq_mag_reg[i] <= ns_mag_reg[i];
                sq_reg[i]     <= SQ_W'(ns_mag_reg[i]) * SQ_W'(ns_mag_reg[i]);
            end
        end
    end

    // sum of squares
    logic             ss_vld_reg;
    logic [SUM_W-1:0] ss_sum_reg;
    logic [RS_W-1:0]  ss_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ss_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            ss_vld_reg <= sq_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ss_sum_reg  <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            ss_side_reg <= {sq_hit_reg, sq_zero_reg, sq_neg_reg,
                            sq_mag_reg[2], sq_mag_reg[1], sq_mag_reg[0]};
        end
    end

    logic            rt_vld;
    logic [RT_W-1:0] rt_len;
    logic [RS_W-1:0] rt_side;

    cprg_sqrt #(
        .RT_W (RT_W),
        .S_W  (RS_W)
    ) u_len_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .vld_in   (ss_vld_reg),
        .rad      (ss_sum_reg),
        .side_in  (ss_side_reg),
        .vld_out  (rt_vld),
        .root     (rt_len),
        .side_out (rt_side)
    );

    // rounded mag * 2^(DW-2) / len
    logic [2:0][NN_W-1:0] nd_num;
    logic [2:0][ND_W-1:0] nd_den;
    logic [2:0][NQ_W-1:0] nd_quo;
    logic [4:0]           nd_side;
    logic                 nd_vld;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nd_num[i] = (NN_W'(rt_side[NORM_W*i +: NORM_W]) << (DW - 1)) + NN_W'(rt_len);
            nd_den[i] = {rt_len, 1'b0};
        end
    end

    cprg_div #(
        .LANES (3),
        .N_W   (NN_W),
        .D_W   (ND_W),
        .Q_W   (NQ_W),
        .S_W   (5)
    ) u_norm_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .vld_in   (rt_vld),
        .num      (nd_num),
        .den      (nd_den),
        .side_in  (rt_side[RS_W-1 -: 5]),
        .vld_out  (nd_vld),
        .quo      (nd_quo),
        .side_out (nd_side)
    );

    // output register; side holds hit, zero length, signs z y x
    logic                 hit_reg;
    logic signed [DW-1:0] dir_reg [3];
    logic [DW-1:0]        q_ext [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_ext[i] = DW'(nd_quo[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= nd_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg <= nd_side[4];
            for (int i = 0; i < 3; i++)
            begin
                if (!nd_side[4] || nd_side[3])
                begin
                    dir_reg[i] <= '0;
                end
                else if (nd_side[i])
                begin
                    dir_reg[i] <= $signed(-q_ext[i]);
                end
                else
                begin
                    dir_reg[i] <= $signed(q_ext[i]);
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign dir_x     = dir_reg[0];
    assign dir_y     = dir_reg[1];
    assign dir_z     = dir_reg[2];

endmodule
`default_nettype wire
